// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the crash detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define CHK_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tscd_pkg.sv =====
// ----------------------------------------------------------------------------
// tscd_pkg
// Widths, angle constants and the arctangent table of the crash detector.
// ----------------------------------------------------------------------------
package tscd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  // CORDIC vector and angle widths (angle in 1/65536 degree)
  localparam int CORDIC_W = 36;
  localparam int ANGLE_W  = 26;

  // Serial divider: signed numerator, positive constant divisor
  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 28;

  // Serial square root: one root bit per beat of the shifter
  localparam int SQRT_OUT_W = 32;
  localparam int SQRT_IN_W  = 2 * SQRT_OUT_W;

  localparam logic signed [ANGLE_W-1:0] DEG_90 = 26'sd5898240;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/tilt_shock_crash_detector_unit.sv =====
// ----------------------------------------------------------------------------
// tilt_shock_crash_detector_unit
// Crash detector: gravity low pass, smoothed shock peak, complementary
// roll/pitch filter and a held alarm, over one serial divider, one serial
// square root and one CORDIC shared by a sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake                   beat carries
//  sample    sample_valid / sample_stall op, acc_x/y/z, rate_x/y, elapsed_us
//  result    result_valid / result_stall alarm, peak_shock, total_accel,
//                                        roll_angle, pitch_angle, window_end
//  config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
//  A tick beat passes through ST_TICK and ST_DONE to a loaded result.
//  A sensor beat is dominated by eight passes of the serial divider, plus
//  three square roots and two 16-step CORDICs.
//  Reset is synchronous on rst and clears all filter state, counters and
//  configuration to their defaults; no clearing pass is needed.
//  The result register lets the next sample beat in while a result waits;
//  a stalled result holds until taken, and the sequencer waits on it.
// ----------------------------------------------------------------------------
module tilt_shock_crash_detector_unit (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic               op,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic        [19:0] elapsed_us,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic               alarm,
  output logic        [15:0] peak_shock,
  output logic        [15:0] total_accel,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic               window_end,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [15:0] cfg_data
);
  import tscd_pkg::*;

  localparam logic [2:0] CFG_SHOCK_THR = 3'd0;
  localparam logic [2:0] CFG_TILT_THR  = 3'd1;
  localparam logic [2:0] CFG_HOLD      = 3'd2;
  localparam logic [2:0] CFG_PERIOD    = 3'd3;

  localparam logic signed [23:0] ANG_LIM = 24'sd5898240;   // 180 deg, 8 frac bits
  localparam logic        [23:0] ANG_90  = 24'd2949120;
  localparam logic        [23:0] SS_CAP  = 24'hFFFFFF;

  typedef enum logic [24:0] {
    ST_IDLE       = 25'h0000001,
    ST_TICK       = 25'h0000002,
    ST_SQ         = 25'h0000004,
    ST_TOT_GO     = 25'h0000008,
    ST_TOT_WAIT   = 25'h0000010,
    ST_GRAV_GO    = 25'h0000020,
    ST_GRAV_WAIT  = 25'h0000040,
    ST_LSQ        = 25'h0000080,
    ST_RAW_GO     = 25'h0000100,
    ST_RAW_WAIT   = 25'h0000200,
    ST_SS_GO      = 25'h0000400,
    ST_SS_WAIT    = 25'h0000800,
    ST_ROLL_GO    = 25'h0001000,
    ST_ROLL_WAIT  = 25'h0002000,
    ST_PX_GO      = 25'h0004000,
    ST_PX_WAIT    = 25'h0008000,
    ST_PITCH_GO   = 25'h0010000,
    ST_PITCH_WAIT = 25'h0020000,
    ST_GMUL       = 25'h0040000,
    ST_GYRO_GO    = 25'h0080000,
    ST_GYRO_WAIT  = 25'h0100000,
    ST_FILT_GO    = 25'h0200000,
    ST_FILT_WAIT  = 25'h0400000,
    ST_ALARM      = 25'h0800000,
    ST_DONE       = 25'h1000000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] shock_thr;
  logic [13:0] tilt_thr;
  logic [15:0] hold_ms;
  logic [15:0] period_ms;

  // filter and counter state
  logic signed [23:0] grav [3];
  logic               seeded;
  logic        [23:0] ss;
  logic        [15:0] peak;
  logic signed [23:0] roll_st;
  logic signed [23:0] pitch_st;
  logic               alarm_flag;
  logic        [15:0] alarm_ms;
  logic        [15:0] win_ms;
  logic        [15:0] total;
  logic               wend;

  // latched sample and scratch
  logic signed [15:0] ax, ay, az, rx, ry;
  logic        [19:0] us;
  logic        [1:0]  cnt;
  logic               sel;
  logic        [49:0] acc;
  logic        [31:0] yz;
  logic        [24:0] raw;
  logic        [31:0] px;
  logic signed [24:0] acc_roll;
  logic signed [24:0] acc_pitch;
  logic signed [35:0] prod;
  logic signed [24:0] gyro;

  // shared units
  logic                        div_start, div_done;
  logic signed [DIV_NUM_W-1:0] div_num, div_q;
  logic        [DIV_DEN_W-1:0] div_den;
  logic                        sqrt_start, sqrt_done;
  logic        [SQRT_IN_W-1:0] sqrt_in;
  logic       [SQRT_OUT_W-1:0] sqrt_root;
  logic                        cor_start, cor_done;
  logic signed  [CORDIC_W-1:0] cor_y, cor_x;
  logic signed   [ANGLE_W-1:0] cor_z;

  // datapath helpers
  logic signed [15:0]          a_sel;
  logic        [31:0]          a_sq;
  logic signed [23:0]          g0;
  logic signed [24:0]          l_sel;
  logic signed [49:0]          l_sq;
  logic signed [23:0]          st_sel;
  logic signed [24:0]          acca_sel;
  logic signed [15:0]          rate_sel;
  logic signed [DIV_NUM_W-1:0] grav_num, ss_num, gyro_num, filt_num;
  logic        [23:0]          ss_new;
  logic signed [23:0]          filt_sat;
  logic signed [26:0]          z_round;
  logic        [15:0]          win_inc, al_inc;
  logic                        trig;
  logic signed [24:0]          roll_sum, pitch_sum;
  logic        [23:0]          tilt_lim;

  function automatic logic [23:0] fold_ang(input logic signed [23:0] a);
    logic [23:0] m;
    m = (a < 0) ? 24'(-a) : 24'(a);
    if (m > ANG_90) m = 24'(ANG_LIM) - m;
    return m;
  endfunction

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;

  always_comb begin
    case (cnt)
      2'd0:    a_sel = ax;
      2'd1:    a_sel = ay;
      default: a_sel = az;
    endcase
  end

  assign a_sq  = 32'(a_sel * a_sel);
  assign g0    = seeded ? grav[cnt] : $signed({a_sel, 8'h00});
  assign l_sel = 25'($signed({a_sel, 8'h00})) - 25'(grav[cnt]);
  assign l_sq  = l_sel * l_sel;

  assign st_sel   = sel ? pitch_st : roll_st;
  assign acca_sel = sel ? acc_pitch : acc_roll;
  assign rate_sel = sel ? ry : rx;

  // rdiv(n, d) = floor((2n + d) / 2d)
  assign grav_num = DIV_NUM_W'(g0) * 46 + DIV_NUM_W'(a_sel) * 1024 + 25;
  assign ss_num   = $signed(DIV_NUM_W'(ss) * 6 + DIV_NUM_W'(raw) * 4 + 5);
  assign gyro_num = DIV_NUM_W'(prod) * 65536 + 131000000;
  assign filt_num = (DIV_NUM_W'(st_sel) + DIV_NUM_W'(gyro)) * 48
                    + DIV_NUM_W'(acca_sel) * 2 + 25;

  always_comb begin
    div_start = 1'b0;
    div_num   = grav_num;
    div_den   = DIV_DEN_W'(50);
    unique case (state)
      ST_GRAV_GO: begin
        div_start = 1'b1;
      end
      ST_SS_GO: begin
        div_start = 1'b1;
        div_num   = ss_num;
        div_den   = DIV_DEN_W'(10);
      end
      ST_GYRO_GO: begin
        div_start = 1'b1;
        div_num   = gyro_num;
        div_den   = DIV_DEN_W'(262000000);
      end
      ST_FILT_GO: begin
        div_start = 1'b1;
        div_num   = filt_num;
      end
      default: ;
    endcase
  end

  always_comb begin
    sqrt_start = 1'b0;
    sqrt_in    = SQRT_IN_W'(32'(acc[31:0] + yz));
    unique case (state)
      ST_TOT_GO: sqrt_start = 1'b1;
      ST_RAW_GO: begin
        sqrt_start = 1'b1;
        sqrt_in    = SQRT_IN_W'(acc);
      end
      ST_PX_GO: begin
        sqrt_start = 1'b1;
        sqrt_in    = {yz, 32'h0};
      end
      default: ;
    endcase
  end

  always_comb begin
    cor_start = 1'b0;
    cor_y     = CORDIC_W'(ay) * 65536;
    cor_x     = CORDIC_W'(az) * 65536;
    unique case (state)
      ST_ROLL_GO: cor_start = 1'b1;
      ST_PITCH_GO: begin
        cor_start = 1'b1;
        cor_y     = -(CORDIC_W'(ax) * 65536);
        cor_x     = $signed(CORDIC_W'(px));
      end
      default: ;
    endcase
  end

  // shock: clamp smoothed value; angle: 1/65536 deg to 1/128 deg with 8 frac bits
  assign ss_new  = (div_q > $signed(DIV_NUM_W'(SS_CAP))) ? SS_CAP : div_q[23:0];
  assign z_round = 27'(cor_z) + 27'sd1;

  always_comb begin
    if (div_q > DIV_NUM_W'(ANG_LIM)) filt_sat = ANG_LIM;
    else if (div_q < -DIV_NUM_W'(ANG_LIM)) filt_sat = -ANG_LIM;
    else filt_sat = div_q[23:0];
  end

  assign win_inc  = (win_ms != 16'hFFFF) ? win_ms + 16'd1 : win_ms;
  assign al_inc   = (alarm_ms != 16'hFFFF) ? alarm_ms + 16'd1 : alarm_ms;
  assign tilt_lim = {2'b00, tilt_thr, 8'h00};
  assign trig     = (peak > shock_thr) &&
                    ((fold_ang(roll_st) > tilt_lim) || (fold_ang(pitch_st) > tilt_lim));

  assign roll_sum  = 25'(roll_st) + 25'sd128;
  assign pitch_sum = 25'(pitch_st) + 25'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      shock_thr    <= 16'd5120;
      tilt_thr     <= 14'd6400;
      hold_ms      <= 16'd2000;
      period_ms    <= 16'd1000;
      grav[0]      <= '0;
      grav[1]      <= '0;
      grav[2]      <= '0;
      seeded       <= 1'b0;
      ss           <= '0;
      peak         <= '0;
      roll_st      <= '0;
      pitch_st     <= '0;
      alarm_flag   <= 1'b0;
      alarm_ms     <= '0;
      win_ms       <= '0;
      total        <= '0;
      wend         <= 1'b0;
      cnt          <= '0;
      sel          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SHOCK_THR: shock_thr <= cfg_data;
          CFG_TILT_THR:  tilt_thr  <= cfg_data[13:0];
          CFG_HOLD:      hold_ms   <= cfg_data;
          CFG_PERIOD:    period_ms <= cfg_data;
          default: ;
        endcase
      end

      // drop a result once taken, unless the next one loads in this cycle
      if (result_valid && !result_stall && state != ST_DONE) result_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            ax  <= acc_x;
            ay  <= acc_y;
            az  <= acc_z;
            rx  <= rate_x;
            ry  <= rate_y;
            us  <= elapsed_us;
            cnt <= '0;
            sel <= 1'b0;
            state <= op ? ST_TICK : ST_SQ;
          end
        end
        ST_TICK: begin
          if (win_inc >= period_ms) begin
            wend   <= 1'b1;
            peak   <= '0;
            win_ms <= '0;
          end else begin
            wend   <= 1'b0;
            win_ms <= win_inc;
          end
          if (alarm_flag) begin
            alarm_ms <= al_inc;
            if (al_inc >= hold_ms) alarm_flag <= 1'b0;
          end
          state <= ST_DONE;
        end
        ST_SQ: begin
          // x^2 into acc, y^2 + z^2 into yz
          case (cnt)
            2'd0:    acc <= 50'(a_sq);
            2'd1:    yz  <= a_sq;
            default: yz  <= yz + a_sq;
          endcase
          if (cnt == 2'd2) begin
            cnt   <= '0;
            state <= ST_TOT_GO;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        ST_TOT_GO:   state <= ST_TOT_WAIT;
        ST_TOT_WAIT: begin
          if (sqrt_done) begin
            total <= sqrt_root[15:0];
            state <= ST_GRAV_GO;
          end
        end
        ST_GRAV_GO:   state <= ST_GRAV_WAIT;
        ST_GRAV_WAIT: begin
          if (div_done) begin
            grav[cnt] <= div_q[23:0];
            if (cnt == 2'd2) begin
              seeded <= 1'b1;
              cnt    <= '0;
              state  <= ST_LSQ;
            end else begin
              cnt   <= cnt + 2'd1;
              state <= ST_GRAV_GO;
            end
          end
        end
        ST_LSQ: begin
          // sum of squared linear acceleration
          if (cnt == 2'd0) acc <= 50'(l_sq);
          else acc <= acc + 50'(l_sq);
          if (cnt == 2'd2) begin
            cnt   <= '0;
            state <= ST_RAW_GO;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        ST_RAW_GO:   state <= ST_RAW_WAIT;
        ST_RAW_WAIT: begin
          if (sqrt_done) begin
            raw   <= sqrt_root[24:0];
            state <= ST_SS_GO;
          end
        end
        ST_SS_GO:   state <= ST_SS_WAIT;
        ST_SS_WAIT: begin
          if (div_done) begin
            ss <= ss_new;
            if (ss_new[23:8] > peak) peak <= ss_new[23:8];
            state <= ST_ROLL_GO;
          end
        end
        ST_ROLL_GO:   state <= ST_ROLL_WAIT;
        ST_ROLL_WAIT: begin
          if (cor_done) begin
            acc_roll <= z_round[25:1];
            state    <= ST_PX_GO;
          end
        end
        ST_PX_GO:   state <= ST_PX_WAIT;
        ST_PX_WAIT: begin
          if (sqrt_done) begin
            px    <= sqrt_root;
            state <= ST_PITCH_GO;
          end
        end
        ST_PITCH_GO:   state <= ST_PITCH_WAIT;
        ST_PITCH_WAIT: begin
          if (cor_done) begin
            acc_pitch <= z_round[25:1];
            state     <= ST_GMUL;
          end
        end
        ST_GMUL: begin
          prod  <= 36'(rate_sel * $signed({1'b0, us}));
          state <= ST_GYRO_GO;
        end
        ST_GYRO_GO:   state <= ST_GYRO_WAIT;
        ST_GYRO_WAIT: begin
          if (div_done) begin
            gyro  <= div_q[24:0];
            state <= ST_FILT_GO;
          end
        end
        ST_FILT_GO:   state <= ST_FILT_WAIT;
        ST_FILT_WAIT: begin
          if (div_done) begin
            if (sel) begin
              pitch_st <= filt_sat;
              state    <= ST_ALARM;
            end else begin
              roll_st <= filt_sat;
              sel     <= 1'b1;
              state   <= ST_GMUL;
            end
          end
        end
        ST_ALARM: begin
          // a raised alarm keeps its hold running
          if (trig && !alarm_flag) begin
            alarm_flag <= 1'b1;
            alarm_ms   <= '0;
          end
          wend  <= 1'b0;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold while the previous result is still stalled
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            alarm        <= alarm_flag;
            peak_shock   <= peak;
            total_accel  <= total;
            roll_angle   <= roll_sum[23:8];
            pitch_angle  <= pitch_sum[23:8];
            window_end   <= wend;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  tscd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  tscd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  tscd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_z)
  );

endmodule

// ===== rtl/core/tscd_div.sv =====
// ----------------------------------------------------------------------------
// tscd_div
// Restoring divider, one quotient bit per cycle, floor of signed / positive.
// ----------------------------------------------------------------------------
module tscd_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [tscd_pkg::DIV_NUM_W-1:0] num,
  input  logic        [tscd_pkg::DIV_DEN_W-1:0] den,
  output logic                                  done,
  output logic signed [tscd_pkg::DIV_NUM_W-1:0] quot
);
  import tscd_pkg::*;

  localparam int MAG_W = DIV_NUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W);

  logic                       run;
  logic                       neg;
  logic [CNT_W-1:0]           cnt;
  logic [MAG_W-1:0]           mag;
  logic [DIV_DEN_W-1:0]       rem;
  logic [DIV_DEN_W-1:0]       dvs;
  logic signed [DIV_NUM_W-1:0] num_abs;
  logic [DIV_DEN_W:0]         rem_sh;
  logic                       ge;
  logic [MAG_W-1:0]           mag_next;

  // floor(n/d) for n < 0 is -((-n + d - 1) / d)
  assign num_abs = num[DIV_NUM_W-1] ? (-num + $signed(DIV_NUM_W'(den)) - 1) : num;

  assign rem_sh   = {rem, mag[MAG_W-1]};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign mag_next = {mag[MAG_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        neg <= num[DIV_NUM_W-1];
        mag <= num_abs[MAG_W-1:0];
        rem <= '0;
        dvs <= den;
        cnt <= '0;
      end else if (run) begin
        rem <= ge ? DIV_DEN_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DEN_W-1:0];
        mag <= mag_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -$signed({1'b0, mag_next}) : $signed({1'b0, mag_next});
        end
      end
    end
  end

endmodule

// ===== rtl/core/tscd_sqrt.sv =====
// ----------------------------------------------------------------------------
// tscd_sqrt
// Bit-pair serial integer square root, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module tscd_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tscd_pkg::SQRT_IN_W-1:0]   radicand,
  output logic                             done,
  output logic [tscd_pkg::SQRT_OUT_W-1:0]  root
);
  import tscd_pkg::*;

  localparam int REM_W = SQRT_OUT_W + 2;
  localparam int CNT_W = $clog2(SQRT_OUT_W);

  logic                    run;
  logic [CNT_W-1:0]        cnt;
  logic [SQRT_IN_W-1:0]    val;
  logic [REM_W-1:0]        rem;
  logic [SQRT_OUT_W-1:0]   acc;
  logic [REM_W+1:0]        rem_sh;
  logic [REM_W+1:0]        trial;
  logic                    ge;
  logic [SQRT_OUT_W-1:0]   acc_next;

  assign rem_sh   = {rem, val[SQRT_IN_W-1 -: 2]};
  assign trial    = (REM_W + 2)'({acc, 2'b01});
  assign ge       = (rem_sh >= trial);
  assign acc_next = {acc[SQRT_OUT_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        val <= radicand;
        rem <= '0;
        acc <= '0;
        cnt <= '0;
      end else if (run) begin
        rem <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        val <= {val[SQRT_IN_W-3:0], 2'b00};
        acc <= acc_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQRT_OUT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          root <= acc_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/tscd_cordic.sv =====
// ----------------------------------------------------------------------------
// tscd_cordic
// Vectoring CORDIC, one micro-rotation per cycle, atan2 in 1/65536 degree.
// ----------------------------------------------------------------------------
module tscd_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [tscd_pkg::CORDIC_W-1:0] y_in,
  input  logic signed [tscd_pkg::CORDIC_W-1:0] x_in,
  output logic                                 done,
  output logic signed [tscd_pkg::ANGLE_W-1:0]  angle
);
  import tscd_pkg::*;

  logic                       run;
  logic [4:0]                 idx;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [ANGLE_W-1:0]  z;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [ANGLE_W-1:0]  z_next;

  assign xs     = x >>> idx;
  assign ys     = y >>> idx;
  assign z_next = (y > 0) ? z + atan_entry(idx) : z - atan_entry(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        idx <= '0;
        if (x_in == 0 && y_in == 0) begin
          // zero vector: angle is zero
          angle <= '0;
          done  <= 1'b1;
        end else begin
          run <= 1'b1;
          if (x_in < 0 && y_in >= 0) begin
            x <= y_in;
            y <= -x_in;
            z <= DEG_90;
          end else if (x_in < 0) begin
            x <= -y_in;
            y <= x_in;
            z <= -DEG_90;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end
      end else if (run) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
        end else begin
          x <= x - ys;
          y <= y + xs;
        end
        z   <= z_next;
        idx <= idx + 1'b1;
        if (idx == 5'(CORDIC_ITERS - 1)) begin
          run   <= 1'b0;
          done  <= 1'b1;
          angle <= z_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/tscd_checker.sv =====
// ----------------------------------------------------------------------------
// tscd_checker
// Port-level assertions for the crash detector, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tscd_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic               alarm,
  input logic        [15:0] peak_shock,
  input logic        [15:0] total_accel,
  input logic signed [15:0] roll_angle,
  input logic signed [15:0] pitch_angle,
  input logic               window_end
);

  // a stalled result beat stays and holds its payload
  `CHK_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(alarm) && $stable(peak_shock) && $stable(total_accel) && $stable(roll_angle) && $stable(pitch_angle) && $stable(window_end), "stalled result changed")

  // one item at a time: busy right after an accepted beat
  `CHK_NEXT(a_busy_after_accept, clk, rst, sample_valid && !sample_stall, sample_stall, "sample taken while busy")

  // a closing window always reports a cleared peak
  `CHK_IMPLIES(a_window_clears_peak, clk, rst, result_valid && window_end, peak_shock == 16'd0, "peak not cleared at window end")

  // filtered angles stay within half a turn
  `CHK_IMPLIES(a_angle_range, clk, rst, result_valid, (roll_angle <= 16'sd23040) && (roll_angle >= -16'sd23040) && (pitch_angle <= 16'sd23040) && (pitch_angle >= -16'sd23040), "angle out of range")

endmodule

bind tilt_shock_crash_detector_unit tscd_checker u_tscd_checker (.*);
